@@ hdl/angle_rate_kalman_filter_core_defines.svh @@
// assertion macros for the angle and rate kalman filter
`ifndef ANGLE_RATE_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_RATE_KALMAN_FILTER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define ARKF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ARKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/arkf_pkg.sv @@
// ----------------------------------------------------------------------------
// arkf_pkg
// types and constants shared by the angle and rate kalman filter
// ----------------------------------------------------------------------------
package arkf_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MEAS_NOISE  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PERIOD      = 2'd3;

   localparam logic [31:0] RST_ANGLE_NOISE = 32'd1073742;
   localparam logic [31:0] RST_BIAS_NOISE  = 32'd3221225;
   localparam logic [31:0] RST_MEAS_NOISE  = 32'd536870912;
   localparam logic [31:0] RST_PERIOD      = 32'd10737418;
   localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRED_ANG,
      ST_PRED_P00,
      ST_PRED_P01,
      ST_PRED_P11,
      ST_DIV_START0,
      ST_DIV_WAIT0,
      ST_DIV_START1,
      ST_DIV_WAIT1,
      ST_CORR_P00,
      ST_CORR_P01,
      ST_CORR_P10,
      ST_CORR_P11,
      ST_CORR_ANG,
      ST_CORR_BIAS,
      ST_WRITE,
      ST_OUT
   } state_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7fffffff;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

@@ hdl/angle_rate_kalman_filter_core.sv @@
// ----------------------------------------------------------------------------
// angle_rate_kalman_filter_core
// two-state angle and gyro bias kalman filter, one filter per axis
// ----------------------------------------------------------------------------
// usage: a transaction on req_ carries an axis, a tilt angle and a gyro rate.
// the block accepts it only when idle, then steps through predict and correct
// with one shared multiplier and a bit-serial divider (two gains per sample).
// most of the time from acceptance to rsp_valid is spent in the divider.
// the result is held in the output register until rsp_ready; req_ready stays
// low until it is taken, so a stalled receiver holds the block.
// an axis beyond NUM_AXES changes no state and returns zero fields.
// reset restores the default noises and period, zeroes the estimates and
// sets both diagonal covariances to one. csr_ writes take effect at the edge.
// ----------------------------------------------------------------------------
module angle_rate_kalman_filter_core #(
   parameter int unsigned NUM_AXES = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_axis,
   input  logic signed [31:0]  req_measured_angle,
   input  logic signed [31:0]  req_gyro_rate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_axis_out,
   output logic signed [31:0]  rsp_filtered_angle,
   output logic signed [31:0]  rsp_corrected_rate,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data
);
   logic [31:0] q_ang_ff, q_bias_ff, r_meas_ff, dt_ff;

   logic signed [31:0] ang_st_ff  [NUM_AXES];
   logic signed [31:0] bias_st_ff [NUM_AXES];
   logic signed [31:0] p00_st_ff  [NUM_AXES];
   logic signed [31:0] p01_st_ff  [NUM_AXES];
   logic signed [31:0] p10_st_ff  [NUM_AXES];
   logic signed [31:0] p11_st_ff  [NUM_AXES];

   arkf_pkg::state_type state_ff, state_in;
   logic sub_ff, sub_in;
   logic axis_ff, meas_dummy;
   logic signed [31:0] meas_ff, rate_ff;
   logic signed [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] ang_in, bias_in, p00_in, p01_in, p10_in, p11_in;
   logic signed [31:0] n00_ff, n01_ff, n00_in, n01_in;
   logic signed [31:0] k0_ff, k1_ff, k0_in, k1_in;
   logic signed [31:0] out_ang_ff, out_rate_ff, out_ang_in, out_rate_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [40:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] mul_p;
   logic div_start, div_done;
   logic signed [31:0] div_num, div_gain;
   logic signed [33:0] e_full;
   logic axis_ok;

   arkf_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(mul_p));
   arkf_div u_div (.clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(e_full[32:0]), .done(div_done), .gain(div_gain));

   assign meas_dummy = 1'b0;
   assign axis_ok = (32'(req_axis) < NUM_AXES);
   assign e_full = 34'(r_meas_ff) + 34'(n00_ff);
   assign req_ready = (state_ff == arkf_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_axis_out = axis_ff;
   assign rsp_filtered_angle = out_ang_ff;
   assign rsp_corrected_rate = out_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ang_ff <= arkf_pkg::RST_ANGLE_NOISE;
         q_bias_ff <= arkf_pkg::RST_BIAS_NOISE;
         r_meas_ff <= arkf_pkg::RST_MEAS_NOISE;
         dt_ff <= arkf_pkg::RST_PERIOD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            arkf_pkg::CSR_ANGLE_NOISE: q_ang_ff <= csr_write_data;
            arkf_pkg::CSR_BIAS_NOISE:  q_bias_ff <= csr_write_data;
            arkf_pkg::CSR_MEAS_NOISE:  r_meas_ff <= csr_write_data;
            arkf_pkg::CSR_PERIOD:      dt_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer: a product is issued with sub_ff low and used with sub_ff high
   always_comb begin
      state_in = state_ff; sub_in = 1'b0;
      ang_in = ang_ff; bias_in = bias_ff; p00_in = p00_ff; p01_in = p01_ff;
      p10_in = p10_ff; p11_in = p11_ff; n00_in = n00_ff; n01_in = n01_ff;
      k0_in = k0_ff; k1_in = k1_ff;
      out_ang_in = out_ang_ff; out_rate_in = out_rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a = '0; mul_b = '0; div_start = 1'b0; div_num = n00_ff;
      unique case (state_ff)
         arkf_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (axis_ok) state_in = arkf_pkg::ST_PRED_ANG;
               else rsp_valid_in = 1'b1;
            end
         end
         arkf_pkg::ST_PRED_ANG: begin
            mul_a = 41'(arkf_pkg::sat32(64'(rate_ff) - 64'(bias_ff)));
            mul_b = 33'(dt_ff);
            sub_in = !sub_ff;
            if (sub_ff) begin
               ang_in = arkf_pkg::sat32(64'(ang_ff) + mul_p);
               state_in = arkf_pkg::ST_PRED_P00;
            end
         end
         arkf_pkg::ST_PRED_P00: begin
            mul_a = 41'(q_ang_ff) - 41'(p01_ff) - 41'(p10_ff);
            mul_b = 33'(dt_ff);
            sub_in = !sub_ff;
            if (sub_ff) begin
               p00_in = arkf_pkg::sat32(64'(p00_ff) + mul_p);
               state_in = arkf_pkg::ST_PRED_P01;
            end
         end
         arkf_pkg::ST_PRED_P01: begin
            mul_a = -41'(p11_ff);
            mul_b = 33'(dt_ff);
            sub_in = !sub_ff;
            if (sub_ff) begin
               p01_in = arkf_pkg::sat32(64'(p01_ff) + mul_p);
               p10_in = arkf_pkg::sat32(64'(p10_ff) + mul_p);
               state_in = arkf_pkg::ST_PRED_P11;
            end
         end
         arkf_pkg::ST_PRED_P11: begin
            mul_a = 41'(q_bias_ff);
            mul_b = 33'(dt_ff);
            sub_in = !sub_ff;
            if (sub_ff) begin
               p11_in = arkf_pkg::sat32(64'(p11_ff) + mul_p);
               n00_in = p00_ff; n01_in = p01_ff;
               state_in = arkf_pkg::ST_DIV_START0;
            end
         end
         arkf_pkg::ST_DIV_START0: begin
            if (e_full > 34'sd0) begin
               div_start = 1'b1; div_num = n00_ff;
               state_in = arkf_pkg::ST_DIV_WAIT0;
            end else begin
               k0_in = '0; k1_in = '0;
               state_in = arkf_pkg::ST_CORR_P00;
            end
         end
         arkf_pkg::ST_DIV_WAIT0: if (div_done) begin
            k0_in = div_gain; state_in = arkf_pkg::ST_DIV_START1;
         end
         arkf_pkg::ST_DIV_START1: begin
            div_start = 1'b1; div_num = p10_ff;
            state_in = arkf_pkg::ST_DIV_WAIT1;
         end
         arkf_pkg::ST_DIV_WAIT1: if (div_done) begin
            k1_in = div_gain; state_in = arkf_pkg::ST_CORR_P00;
         end
         arkf_pkg::ST_CORR_P00: begin
            mul_a = 41'(n00_ff); mul_b = 33'(k0_ff); sub_in = !sub_ff;
            if (sub_ff) begin
               p00_in = arkf_pkg::sat32(64'(n00_ff) - mul_p);
               state_in = arkf_pkg::ST_CORR_P01;
            end
         end
         arkf_pkg::ST_CORR_P01: begin
            mul_a = 41'(n01_ff); mul_b = 33'(k0_ff); sub_in = !sub_ff;
            if (sub_ff) begin
               p01_in = arkf_pkg::sat32(64'(n01_ff) - mul_p);
               state_in = arkf_pkg::ST_CORR_P10;
            end
         end
         arkf_pkg::ST_CORR_P10: begin
            mul_a = 41'(n00_ff); mul_b = 33'(k1_ff); sub_in = !sub_ff;
            if (sub_ff) begin
               p10_in = arkf_pkg::sat32(64'(p10_ff) - mul_p);
               state_in = arkf_pkg::ST_CORR_P11;
            end
         end
         arkf_pkg::ST_CORR_P11: begin
            mul_a = 41'(n01_ff); mul_b = 33'(k1_ff); sub_in = !sub_ff;
            if (sub_ff) begin
               p11_in = arkf_pkg::sat32(64'(p11_ff) - mul_p);
               state_in = arkf_pkg::ST_CORR_ANG;
            end
         end
         arkf_pkg::ST_CORR_ANG: begin
            mul_a = 41'(meas_ff) - 41'(ang_ff); mul_b = 33'(k0_ff); sub_in = !sub_ff;
            if (sub_ff) begin
               ang_in = arkf_pkg::sat32(64'(ang_ff) + mul_p);
               state_in = arkf_pkg::ST_CORR_BIAS;
            end
         end
         arkf_pkg::ST_CORR_BIAS: begin
            // innovation uses the predicted angle held in the output register
            mul_a = 41'(meas_ff) - 41'(out_ang_ff); mul_b = 33'(k1_ff);
            sub_in = !sub_ff;
            if (sub_ff) begin
               bias_in = arkf_pkg::sat32(64'(bias_ff) + mul_p);
               state_in = arkf_pkg::ST_WRITE;
            end
         end
         arkf_pkg::ST_WRITE: begin
            out_ang_in = ang_ff;
            out_rate_in = arkf_pkg::sat32(64'(rate_ff) - 64'(bias_ff));
            state_in = arkf_pkg::ST_OUT;
         end
         arkf_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1; state_in = arkf_pkg::ST_IDLE;
         end
         default: state_in = arkf_pkg::ST_IDLE;
      endcase
      // keep the predicted angle for the bias correction
      if (state_ff == arkf_pkg::ST_CORR_ANG && !sub_ff) out_ang_in = ang_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arkf_pkg::ST_IDLE;
         sub_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            ang_st_ff[i] <= '0; bias_st_ff[i] <= '0;
            p00_st_ff[i] <= arkf_pkg::ONE_Q30; p01_st_ff[i] <= '0;
            p10_st_ff[i] <= '0; p11_st_ff[i] <= arkf_pkg::ONE_Q30;
         end
      end else begin
         state_ff <= state_in;
         sub_ff <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == arkf_pkg::ST_WRITE) begin
            ang_st_ff[axis_ff] <= ang_ff; bias_st_ff[axis_ff] <= bias_ff;
            p00_st_ff[axis_ff] <= p00_ff; p01_st_ff[axis_ff] <= p01_ff;
            p10_st_ff[axis_ff] <= p10_ff; p11_st_ff[axis_ff] <= p11_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         axis_ff <= req_axis | meas_dummy;
         meas_ff <= req_measured_angle;
         rate_ff <= req_gyro_rate;
         if (axis_ok) begin
            ang_ff <= ang_st_ff[req_axis]; bias_ff <= bias_st_ff[req_axis];
            p00_ff <= p00_st_ff[req_axis]; p01_ff <= p01_st_ff[req_axis];
            p10_ff <= p10_st_ff[req_axis]; p11_ff <= p11_st_ff[req_axis];
         end else begin
            out_ang_ff <= '0; out_rate_ff <= '0;
         end
      end else begin
         ang_ff <= ang_in; bias_ff <= bias_in; p00_ff <= p00_in; p01_ff <= p01_in;
         p10_ff <= p10_in; p11_ff <= p11_in;
         out_ang_ff <= out_ang_in; out_rate_ff <= out_rate_in;
      end
      n00_ff <= n00_in; n01_ff <= n01_in; k0_ff <= k0_in; k1_ff <= k1_in;
   end
endmodule

@@ hdl/arkf_mul.sv @@
// ----------------------------------------------------------------------------
// arkf_mul
// shared q30 multiplier: sign-magnitude product rounded half away from zero
// ----------------------------------------------------------------------------
module arkf_mul (
   input  logic               clock,
   input  logic signed [40:0] a,
   input  logic signed [32:0] b,
   output logic signed [63:0] prod
);
   logic        neg_ff;
   logic [39:0] ma;
   logic [31:0] mb;
   logic [71:0] mprod_ff;
   logic [71:0] mprod_in;
   logic [41:0] rounded;

   always_comb begin
      ma = a[40] ? 40'(-a) : a[39:0];
      mb = b[32] ? 32'(-b) : b[31:0];
      mprod_in = 72'(ma) * 72'(mb);
   end

   always_ff @(posedge clock) begin
      mprod_ff <= mprod_in;
      neg_ff <= a[40] ^ b[32];
   end

   always_comb begin
      rounded = 42'((mprod_ff + 72'(1 << 29)) >> 30);
      prod = neg_ff ? -64'(rounded) : 64'(rounded);
   end
endmodule

@@ hdl/arkf_div.sv @@
// ----------------------------------------------------------------------------
// arkf_div
// restoring divider, one quotient bit a cycle, gives saturated q1.30 gain
// ----------------------------------------------------------------------------
module arkf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic        [32:0] den,
   output logic               done,
   output logic signed [31:0] gain
);
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic [61:0] dvd_ff, dvd_in;
   logic [33:0] rem_ff, rem_in;
   logic [61:0] quo_ff, quo_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] trial;
   logic [31:0] mnum;

   always_comb begin
      mnum = num[31] ? 32'(-num) : num;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      trial = {rem_ff[32:0], dvd_ff[61]};
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1; cnt_in = 6'd0; neg_in = num[31];
         dvd_in = {mnum, 30'd0}; rem_in = '0; quo_in = '0; den_in = den;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[60:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[60:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[60:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd61) busy_in = 1'b0;
      end
      if (!busy_ff && cnt_ff == 6'd62) done = 1'b1;
      if (neg_ff) gain = (quo_ff > 62'h80000000) ? 32'sh80000000 : 32'(-quo_ff);
      else gain = (quo_ff > 62'h7fffffff) ? 32'sh7fffffff : quo_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= (!busy_ff && cnt_ff == 6'd62 && !start) ? 6'd0 : cnt_in;
      end
      neg_ff <= neg_in; dvd_ff <= dvd_in; rem_ff <= rem_in;
      quo_ff <= quo_in; den_ff <= den_in;
   end
endmodule

@@ hdl/arkf_checker.sv @@
// ----------------------------------------------------------------------------
// arkf_checker
// port-level checks for the angle and rate kalman filter
// ----------------------------------------------------------------------------
`include "angle_rate_kalman_filter_core_defines.svh"

module arkf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_filtered_angle
);
   `ARKF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `ARKF_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready while result pending")
   `ARKF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered_angle), "result dropped")
endmodule

bind angle_rate_kalman_filter_core arkf_checker u_arkf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_filtered_angle(rsp_filtered_angle)
);
